// File: hw/rtl/tmm_pkg.sv
// Shared constants, types and latencies of the model matrix pipeline.
package tmm_pkg;

   localparam int FIELD_W = 16;
   localparam int OUT_W   = 32;
   localparam int TRIG_W  = 18;
   localparam int QW_W    = 17;
   localparam int T_W     = 13;
   localparam int X_W     = 31;
   localparam int X2_W    = 32;
   localparam int P_W     = 31;
   localparam int M_W     = 30;
   localparam int K_W     = 7;

   localparam int DEG_LIMIT = 23040;
   localparam int QUARTER   = 5760;
   localparam int RAD_STEP  = 292818;

   localparam int NUM_TERMS = 5;
   localparam int unsigned DIV_K [NUM_TERMS] = '{110, 72, 42, 20, 6};
   localparam longint unsigned DIV_M [NUM_TERMS] = '{
      (64'd1 << 32) / 110,
      (64'd1 << 32) / 72,
      (64'd1 << 32) / 42,
      (64'd1 << 32) / 20,
      (64'd1 << 32) / 6
   };

   localparam int QW_LAT    = 3 * NUM_TERMS + 4;
   localparam int SC_LAT    = QW_LAT + 2;
   localparam int MX_LAT    = 5;
   localparam int TOTAL_LAT = SC_LAT + MX_LAT;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_v;
      logic signed [TRIG_W-1:0] cos_v;
   } trig_type;

endpackage

// File: hw/rtl/tmm_quarter_wave.sv
// Pipelined quarter-wave sine polynomial with reciprocal constant division.
module tmm_quarter_wave (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [tmm_pkg::T_W-1:0]    t_in,
   output logic                       out_valid,
   output logic [tmm_pkg::QW_W-1:0]   q_out
);
   import tmm_pkg::*;

   localparam int NSTG = 3 * NUM_TERMS;
   localparam logic [P_W-1:0] ONE30 = P_W'(1) << 30;

   logic [QW_LAT-1:0] vld_ff, vld_in;
   logic [X_W-1:0]    x1_ff, x1_in;
   logic [X_W-1:0]    x_ff [NSTG+1];
   logic [X2_W-1:0]   x2_ff [NSTG+1];
   logic [X2_W-1:0]   x2_in;
   logic [31:0]       tprod;
   logic [2*X_W-1:0]  sq;
   logic [2*X_W-1:0]  xp;
   logic [X2_W-1:0]   y_ff, y_in;
   logic [X2_W:0]     y_round;
   logic [QW_W-1:0]   q_ff, q_in;
   wire  [P_W-1:0]    p_term [NUM_TERMS];

   always_comb begin
      tprod   = {19'b0, t_in} * 32'(RAD_STEP);
      x1_in   = tprod[X_W-1:0];
      sq      = {X_W'(0), x1_ff} * {X_W'(0), x1_ff};
      x2_in   = sq[2*X_W-1 -: X2_W];
      vld_in  = {vld_ff[QW_LAT-2:0], in_valid};
      xp      = {X_W'(0), x_ff[NSTG]} * {X_W'(0), p_term[NUM_TERMS-1]};
      y_in    = xp[2*X_W-1 -: X2_W];
      y_round = {1'b0, y_ff} + (X2_W+1)'(8192);
      q_in    = y_round[14 +: QW_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff    <= x1_in;
      x_ff[0]  <= x1_ff;
      x2_ff[0] <= x2_in;
      for (int k = 1; k <= NSTG; k++) begin
         x_ff[k]  <= x_ff[k-1];
         x2_ff[k] <= x2_ff[k-1];
      end
      y_ff <= y_in;
      q_ff <= q_in;
   end

   for (genvar i = 0; i < NUM_TERMS; i++) begin : g_term
      localparam logic [K_W-1:0] K = K_W'(DIV_K[i]);
      localparam logic [M_W-1:0] M = M_W'(DIV_M[i]);
      logic [P_W-1:0]        p_src;
      logic [X2_W+P_W-1:0]   ap;
      logic [X2_W-1:0]       v_ff, v_in, vb_ff;
      logic [X2_W+M_W-1:0]   bm;
      logic [M_W-1:0]        q0_ff, q0_in, q_fix;
      logic [M_W+K_W-1:0]    qk;
      logic [X2_W:0]         rem;
      logic [P_W-1:0]        p_ff, p_in;

      if (i == 0) begin : g_first
         assign p_src = ONE30;
      end else begin : g_next
         assign p_src = p_term[i-1];
      end

      always_comb begin
         ap    = {P_W'(0), x2_ff[3*i]} * {X2_W'(0), p_src};
         v_in  = ap[X2_W+P_W-2 -: X2_W];
         bm    = {M_W'(0), v_ff} * {X2_W'(0), M};
         q0_in = bm[X2_W +: M_W];
         qk    = {K_W'(0), q0_ff} * {M_W'(0), K};
         rem   = {1'b0, vb_ff} - qk[X2_W:0];
         q_fix = (rem >= (X2_W+1)'(K)) ? q0_ff + M_W'(1) : q0_ff;
         p_in  = ONE30 - {1'b0, q_fix};
      end

      always_ff @(posedge clock) begin
         v_ff  <= v_in;
         q0_ff <= q0_in;
         vb_ff <= v_ff;
         p_ff  <= p_in;
      end

      assign p_term[i] = p_ff;
   end

   assign out_valid = vld_ff[QW_LAT-1];
   assign q_out     = q_ff;

`ifndef SYNTHESIS
   a_term_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (p_term[0] <= ONE30 && p_term[0] != '0))
      else $error("First series term left its range.");
`endif

endmodule

// File: hw/rtl/tmm_sincos.sv
// Angle folding, quadrant selection and sine and cosine of one angle.
module tmm_sincos (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [tmm_pkg::FIELD_W-1:0] angle_in,
   output logic                              out_valid,
   output tmm_pkg::trig_type                 trig_out
);
   import tmm_pkg::*;

   typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_type;

   logic signed [FIELD_W-1:0] a_kept;
   logic signed [FIELD_W:0]   u_wide;
   logic [14:0]               u;
   logic [14:0]               r_wide;
   quad_type                  quad_in, quad_ff;
   quad_type                  quad_dly_ff [QW_LAT];
   logic [T_W-1:0]            r_ff, tr_ff;
   logic                      vld0_ff;
   logic                      fwd_valid, rev_valid;
   logic [QW_W-1:0]           fwd_q, rev_q;
   logic signed [TRIG_W-1:0]  fwd_s, rev_s;
   trig_type                  trig_in, trig_ff;
   logic                      vld_out_ff;

   always_comb begin
      if (angle_in > FIELD_W'(DEG_LIMIT) || angle_in < -FIELD_W'(DEG_LIMIT)) begin
         a_kept = '0;
      end else begin
         a_kept = angle_in;
      end
      u_wide = (a_kept < 0) ? (FIELD_W+1)'(a_kept) + (FIELD_W+1)'(DEG_LIMIT)
                            : (FIELD_W+1)'(a_kept);
      if (u_wide >= (FIELD_W+1)'(DEG_LIMIT)) begin
         u_wide = u_wide - (FIELD_W+1)'(DEG_LIMIT);
      end
      u = u_wide[14:0];
      if (u >= 15'(3 * QUARTER)) begin
         quad_in = QUAD_3;
         r_wide  = u - 15'(3 * QUARTER);
      end else if (u >= 15'(2 * QUARTER)) begin
         quad_in = QUAD_2;
         r_wide  = u - 15'(2 * QUARTER);
      end else if (u >= 15'(QUARTER)) begin
         quad_in = QUAD_1;
         r_wide  = u - 15'(QUARTER);
      end else begin
         quad_in = QUAD_0;
         r_wide  = u;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff    <= 1'b0;
         vld_out_ff <= 1'b0;
      end else begin
         vld0_ff    <= in_valid;
         vld_out_ff <= fwd_valid;
      end
   end

   always_ff @(posedge clock) begin
      quad_ff        <= quad_in;
      r_ff           <= r_wide[T_W-1:0];
      tr_ff          <= T_W'(QUARTER) - r_wide[T_W-1:0];
      quad_dly_ff[0] <= quad_ff;
      for (int k = 1; k < QW_LAT; k++) begin
         quad_dly_ff[k] <= quad_dly_ff[k-1];
      end
      trig_ff <= trig_in;
   end

   tmm_quarter_wave u_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld0_ff),
      .t_in      (r_ff),
      .out_valid (fwd_valid),
      .q_out     (fwd_q)
   );

   tmm_quarter_wave u_rev (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld0_ff),
      .t_in      (tr_ff),
      .out_valid (rev_valid),
      .q_out     (rev_q)
   );

   always_comb begin
      fwd_s = $signed({1'b0, fwd_q});
      rev_s = $signed({1'b0, rev_q});
      unique case (quad_dly_ff[QW_LAT-1])
         QUAD_0: begin
            trig_in.sin_v = fwd_s;
            trig_in.cos_v = rev_s;
         end
         QUAD_1: begin
            trig_in.sin_v = rev_s;
            trig_in.cos_v = -fwd_s;
         end
         QUAD_2: begin
            trig_in.sin_v = -fwd_s;
            trig_in.cos_v = -rev_s;
         end
         default: begin
            trig_in.sin_v = -rev_s;
            trig_in.cos_v = fwd_s;
         end
      endcase
   end

   assign out_valid = vld_out_ff;
   assign trig_out  = trig_ff;

`ifndef SYNTHESIS
   a_pair_aligned: assert property (@(posedge clock) disable iff (reset)
      fwd_valid == rev_valid)
      else $error("Forward and reverse quarter-wave pipes fell out of step.");
`endif

endmodule

// File: hw/rtl/tmm_matrix.sv
// Rotation products, rounding, scaling and saturation of the matrix entries.
module tmm_matrix (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  tmm_pkg::trig_type                  trig_x,
   input  tmm_pkg::trig_type                  trig_y,
   input  tmm_pkg::trig_type                  trig_z,
   input  logic signed [tmm_pkg::FIELD_W-1:0] scl_in [3],
   input  logic signed [tmm_pkg::FIELD_W-1:0] pos_in [3],
   output logic                               out_valid,
   output logic signed [tmm_pkg::OUT_W-1:0]   m_out [3][4]
);
   import tmm_pkg::*;

   localparam int PR_W = 2 * TRIG_W;
   localparam int TR_W = PR_W + TRIG_W;
   localparam int WK_W = 56;
   localparam int E_W  = 28;
   localparam int S_W  = E_W + FIELD_W;

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [S_W-1:0] v);
      logic signed [S_W-1:0] hi;
      logic signed [S_W-1:0] lo;
      hi = S_W'(32'sh7FFF_FFFF);
      lo = -hi - S_W'(1);
      if (v > hi) begin
         return OUT_W'(hi);
      end else if (v < lo) begin
         return OUT_W'(lo);
      end
      return OUT_W'(v);
   endfunction

   logic [MX_LAT-1:0] vld_ff;

   logic signed [PR_W-1:0] cycz_ff, cysz_ff, sxcy_ff, cxcy_ff, cxsz_ff;
   logic signed [PR_W-1:0] cxcz_ff, sxsz_ff, sxcz_ff, sxsy_ff, cxsy_ff;
   logic signed [TRIG_W-1:0] sy1_ff, sz1_ff, cz1_ff, sy2_ff;
   logic signed [PR_W-1:0] cycz2_ff, cysz2_ff, sxcy2_ff, cxcy2_ff;
   logic signed [PR_W-1:0] cxsz2_ff, cxcz2_ff, sxsz2_ff, sxcz2_ff;
   logic signed [TR_W-1:0] t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [E_W-1:0]  e_ff [3][3];
   logic signed [E_W-1:0]  e_in [3][3];
   logic signed [S_W-1:0]  m_ff [3][3];
   logic signed [OUT_W-1:0] o_ff [3][4];
   logic signed [FIELD_W-1:0] scl_ff [3][3];
   logic signed [FIELD_W-1:0] pos_ff [4][3];
   logic signed [WK_W-1:0] half8, half24;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[MX_LAT-2:0], in_valid};
      end
   end

   always_comb begin
      half8  = WK_W'(128);
      half24 = WK_W'(8388608);
      e_in[0][0] = E_W'((WK_W'(cycz2_ff) + half8) >>> 8);
      e_in[0][1] = E_W'((-WK_W'(cysz2_ff) + half8) >>> 8);
      e_in[0][2] = E_W'(WK_W'(sy2_ff) <<< 8);
      e_in[1][0] = E_W'(((WK_W'(cxsz2_ff) <<< 16) + WK_W'(t1_ff) + half24) >>> 24);
      e_in[1][1] = E_W'(((WK_W'(cxcz2_ff) <<< 16) - WK_W'(t2_ff) + half24) >>> 24);
      e_in[1][2] = E_W'((-WK_W'(sxcy2_ff) + half8) >>> 8);
      e_in[2][0] = E_W'(((WK_W'(sxsz2_ff) <<< 16) - WK_W'(t3_ff) + half24) >>> 24);
      e_in[2][1] = E_W'(((WK_W'(sxcz2_ff) <<< 16) + WK_W'(t4_ff) + half24) >>> 24);
      e_in[2][2] = E_W'((WK_W'(cxcy2_ff) + half8) >>> 8);
   end

   always_ff @(posedge clock) begin
      cycz_ff <= PR_W'(trig_y.cos_v) * PR_W'(trig_z.cos_v);
      cysz_ff <= PR_W'(trig_y.cos_v) * PR_W'(trig_z.sin_v);
      sxcy_ff <= PR_W'(trig_x.sin_v) * PR_W'(trig_y.cos_v);
      cxcy_ff <= PR_W'(trig_x.cos_v) * PR_W'(trig_y.cos_v);
      cxsz_ff <= PR_W'(trig_x.cos_v) * PR_W'(trig_z.sin_v);
      cxcz_ff <= PR_W'(trig_x.cos_v) * PR_W'(trig_z.cos_v);
      sxsz_ff <= PR_W'(trig_x.sin_v) * PR_W'(trig_z.sin_v);
      sxcz_ff <= PR_W'(trig_x.sin_v) * PR_W'(trig_z.cos_v);
      sxsy_ff <= PR_W'(trig_x.sin_v) * PR_W'(trig_y.sin_v);
      cxsy_ff <= PR_W'(trig_x.cos_v) * PR_W'(trig_y.sin_v);
      sy1_ff  <= trig_y.sin_v;
      sz1_ff  <= trig_z.sin_v;
      cz1_ff  <= trig_z.cos_v;

      t1_ff    <= TR_W'(sxsy_ff) * TR_W'(cz1_ff);
      t2_ff    <= TR_W'(sxsy_ff) * TR_W'(sz1_ff);
      t3_ff    <= TR_W'(cxsy_ff) * TR_W'(cz1_ff);
      t4_ff    <= TR_W'(cxsy_ff) * TR_W'(sz1_ff);
      cycz2_ff <= cycz_ff;
      cysz2_ff <= cysz_ff;
      sxcy2_ff <= sxcy_ff;
      cxcy2_ff <= cxcy_ff;
      cxsz2_ff <= cxsz_ff;
      cxcz2_ff <= cxcz_ff;
      sxsz2_ff <= sxsz_ff;
      sxcz2_ff <= sxcz_ff;
      sy2_ff   <= sy1_ff;

      for (int r = 0; r < 3; r++) begin
         scl_ff[0][r] <= scl_in[r];
         pos_ff[0][r] <= pos_in[r];
         for (int s = 1; s < 3; s++) begin
            scl_ff[s][r] <= scl_ff[s-1][r];
         end
         for (int s = 1; s < 4; s++) begin
            pos_ff[s][r] <= pos_ff[s-1][r];
         end
      end

      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            e_ff[r][c] <= e_in[r][c];
            m_ff[r][c] <= S_W'(e_ff[r][c]) * S_W'(scl_ff[2][c]);
            o_ff[r][c] <= sat_out((m_ff[r][c] + S_W'(32768)) >>> 16);
         end
         o_ff[r][3] <= OUT_W'(pos_ff[3][r]) <<< 8;
      end
   end

   assign out_valid = vld_ff[MX_LAT-1];
   assign m_out     = o_ff;

`ifndef SYNTHESIS
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (o_ff[2][0] < 32'sd33554432 && o_ff[2][0] > -32'sd33554432))
      else $error("Matrix entry outside the range that the inputs allow.");
`endif

endmodule

// File: hw/rtl/trs_model_matrix.sv
// Top level of the translate-rotate-scale model matrix pipeline.
// One word is taken in every clock cycle, and busy never rises. Each result
// appears on the rsp_ ports for one cycle with rsp_valid, 26 cycles after
// its word was taken, and must be captured then, since the receiver cannot
// hold results off. The latency is set by the sine polynomial pipeline,
// which evaluates a five-term series with one constant division per term
// over nineteen register stages, with one stage before it for angle folding
// and one after it for quadrant selection, followed by five stages of matrix
// products.
module trs_model_matrix (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [tmm_pkg::FIELD_W-1:0] req_pos_x,
   input  logic signed [tmm_pkg::FIELD_W-1:0] req_pos_y,
   input  logic signed [tmm_pkg::FIELD_W-1:0] req_pos_z,
   input  logic signed [tmm_pkg::FIELD_W-1:0] req_angle_x,
   input  logic signed [tmm_pkg::FIELD_W-1:0] req_angle_y,
   input  logic signed [tmm_pkg::FIELD_W-1:0] req_angle_z,
   input  logic signed [tmm_pkg::FIELD_W-1:0] req_scale_x,
   input  logic signed [tmm_pkg::FIELD_W-1:0] req_scale_y,
   input  logic signed [tmm_pkg::FIELD_W-1:0] req_scale_z,
   output logic                               rsp_valid,
   output logic signed [tmm_pkg::OUT_W-1:0]   rsp_row0_col0,
   output logic signed [tmm_pkg::OUT_W-1:0]   rsp_row0_col1,
   output logic signed [tmm_pkg::OUT_W-1:0]   rsp_row0_col2,
   output logic signed [tmm_pkg::OUT_W-1:0]   rsp_row0_col3,
   output logic signed [tmm_pkg::OUT_W-1:0]   rsp_row1_col0,
   output logic signed [tmm_pkg::OUT_W-1:0]   rsp_row1_col1,
   output logic signed [tmm_pkg::OUT_W-1:0]   rsp_row1_col2,
   output logic signed [tmm_pkg::OUT_W-1:0]   rsp_row1_col3,
   output logic signed [tmm_pkg::OUT_W-1:0]   rsp_row2_col0,
   output logic signed [tmm_pkg::OUT_W-1:0]   rsp_row2_col1,
   output logic signed [tmm_pkg::OUT_W-1:0]   rsp_row2_col2,
   output logic signed [tmm_pkg::OUT_W-1:0]   rsp_row2_col3
);
   import tmm_pkg::*;

   logic                      accept;
   logic                      trig_valid;
   trig_type                  trig_x, trig_y, trig_z;
   logic signed [FIELD_W-1:0] scl_dly_ff [SC_LAT][3];
   logic signed [FIELD_W-1:0] pos_dly_ff [SC_LAT][3];
   logic signed [OUT_W-1:0]   m_out [3][4];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      scl_dly_ff[0][0] <= req_scale_x;
      scl_dly_ff[0][1] <= req_scale_y;
      scl_dly_ff[0][2] <= req_scale_z;
      pos_dly_ff[0][0] <= req_pos_x;
      pos_dly_ff[0][1] <= req_pos_y;
      pos_dly_ff[0][2] <= req_pos_z;
      for (int s = 1; s < SC_LAT; s++) begin
         for (int r = 0; r < 3; r++) begin
            scl_dly_ff[s][r] <= scl_dly_ff[s-1][r];
            pos_dly_ff[s][r] <= pos_dly_ff[s-1][r];
         end
      end
   end

   tmm_sincos u_sc_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle_in  (req_angle_x),
      .out_valid (trig_valid),
      .trig_out  (trig_x)
   );

   tmm_sincos u_sc_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle_in  (req_angle_y),
      .out_valid (),
      .trig_out  (trig_y)
   );

   tmm_sincos u_sc_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle_in  (req_angle_z),
      .out_valid (),
      .trig_out  (trig_z)
   );

   tmm_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (trig_valid),
      .trig_x    (trig_x),
      .trig_y    (trig_y),
      .trig_z    (trig_z),
      .scl_in    (scl_dly_ff[SC_LAT-1]),
      .pos_in    (pos_dly_ff[SC_LAT-1]),
      .out_valid (rsp_valid),
      .m_out     (m_out)
   );

   assign rsp_row0_col0 = m_out[0][0];
   assign rsp_row0_col1 = m_out[0][1];
   assign rsp_row0_col2 = m_out[0][2];
   assign rsp_row0_col3 = m_out[0][3];
   assign rsp_row1_col0 = m_out[1][0];
   assign rsp_row1_col1 = m_out[1][1];
   assign rsp_row1_col2 = m_out[1][2];
   assign rsp_row1_col3 = m_out[1][3];
   assign rsp_row2_col0 = m_out[2][0];
   assign rsp_row2_col1 = m_out[2][1];
   assign rsp_row2_col2 = m_out[2][2];
   assign rsp_row2_col3 = m_out[2][3];

`ifndef SYNTHESIS
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, TOTAL_LAT))
      else $error("Result word without a matching request word.");
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##TOTAL_LAT rsp_valid)
      else $error("Request word was lost in the pipeline.");
`endif

endmodule
